>>> rtl/abkf_pkg.sv
`default_nettype none
package abkf_pkg;
    localparam int NUM_REGS   = 5;
    localparam int REG_W      = 17;
    localparam int IDX_W      = 3;
    localparam int MEAS_W     = 26;
    localparam int RATE_W     = 16;
    localparam int DATA_W     = 32;

    localparam logic [IDX_W-1:0] REG_DELTA_T       = 3'd0;
    localparam logic [IDX_W-1:0] REG_RATE_SCALE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_NOISE_ANGLE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_NOISE_BIAS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_NOISE_MEASURE = 3'd4;

    localparam logic [REG_W-1:0] RST_DELTA_T       = 17'd655;
    localparam logic [REG_W-1:0] RST_RATE_SCALE    = 17'd88;
    localparam logic [REG_W-1:0] RST_NOISE_ANGLE   = 17'd66;
    localparam logic [REG_W-1:0] RST_NOISE_BIAS    = 17'd197;
    localparam logic [REG_W-1:0] RST_NOISE_MEASURE = 17'd1966;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CR,      // cr = rate<<F - bias
        ST_ANG,     // angle += cr*rs
        ST_T,       // t = dt*c11
        ST_INNER,   // x = t - c01
        ST_INNER_B, // x -= c10
        ST_INNER_C, // x += na
        ST_C00,     // c00 += dt*inner
        ST_C0110,   // c01 -= t, c10 -= t
        ST_C11,     // c11 += nb*dt
        ST_S,
        ST_K0,
        ST_K0W,
        ST_K1,
        ST_K1W,
        ST_Y,
        ST_CA,      // angle += k0*y
        ST_CB,      // bias += k1*y
        ST_P00,     // c00 -= k0*p00
        ST_P01,     // c01 -= k0*p01
        ST_P10,     // c10 -= k1*p00
        ST_P11,     // c11 -= k1*p01
        ST_OUT
    } abkf_state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB
    } abkf_op_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } abkf_div_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W+1:0] mx;
        logic signed [DATA_W+1:0] mn;
        mx = {3'b000, {(DATA_W-1){1'b1}}};
        mn = {3'b111, {(DATA_W-1){1'b0}}};
        if (v > mx)
            return mx[DATA_W-1:0];
        else if (v < mn)
            return mn[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/abkf_if.sv
`default_nettype none
interface abkf_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/abkf_alu.sv
`default_nettype none
module abkf_alu
    import abkf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic                     clk,
    input  wire abkf_op_t                 op,
    input  wire logic signed [DATA_W-1:0] a,
    input  wire logic signed [DATA_W-1:0] b,
    output logic signed [DATA_W-1:0]      res
);
    // product registered before shift/saturate
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W-1:0] sh;
    logic signed [DATA_W+1:0]   sum;
    logic signed [DATA_W+1:0]   shn;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // arithmetic shift is floor rounding
    assign sh  = prod_reg >>> FRAC_BITS;

    always_comb
    begin
        if (sh > $signed({{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}))
            shn = {3'b000, {(DATA_W-1){1'b1}}};
        else if (sh < $signed({{(DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}}))
            shn = {3'b111, {(DATA_W-1){1'b0}}};
        else
            shn = sh[DATA_W+1:0];
        case (op)
            OP_ADD:  sum = {{2{a[DATA_W-1]}}, a} + {{2{b[DATA_W-1]}}, b};
            OP_SUB:  sum = {{2{a[DATA_W-1]}}, a} - {{2{b[DATA_W-1]}}, b};
            default: sum = shn;
        endcase
        res = sat32(sum);
    end
endmodule
`default_nettype wire

>>> rtl/abkf_div.sv
`default_nettype none
module abkf_div
    import abkf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DATA_W-1:0] num,
    input  wire logic signed [DATA_W-1:0] den,
    output abkf_div_ctrl_t                ctrl,
    output logic signed [DATA_W-1:0]      quo
);
    // restoring divide of |num|<<F by den (den>0), one quotient bit per cycle
    localparam int NW  = DATA_W + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);

    logic [NW-1:0]     q_reg, q_next;
    logic [DATA_W:0]   r_reg, r_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic [NW:0]       qs;
    logic [DATA_W-1:0] mag;

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        mag = num[DATA_W-1] ? DATA_W'(-num) : num;
        trial = {r_reg[DATA_W-1:0], q_reg[NW-1]};
        diff = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next = {mag, {FRAC_BITS{1'b0}}};
            r_next = '0;
            d_next = den;
            neg_next = num[DATA_W-1];
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                r_next = diff;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        qs = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
        if (!neg_reg && q_reg > NW'({(DATA_W-1){1'b1}}))
            quo = {1'b0, {(DATA_W-1){1'b1}}};
        else if (neg_reg && q_reg > NW'({1'b1, {(DATA_W-1){1'b0}}}))
            quo = {1'b1, {(DATA_W-1){1'b0}}};
        else
            quo = qs[DATA_W-1:0];
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign ctrl.done  = done_reg;
endmodule
`default_nettype wire

>>> rtl/angle_bias_kalman_filter_unit.sv
// Two-state Kalman filter: angle estimate and gyro bias, Q(32-F).F fixed point.
// Channels:
//   in_ch  : sink, data = {gyro_rate[15:0], measured_angle[25:0]}
//   out_ch : source, data = {bias_estimate[31:0], filtered_angle[31:0]}
//   cfg    : cfg_we / cfg_idx / cfg_data write port, five registers in order
//            delta_t, rate_scale, noise_angle, noise_bias, noise_measure.
// One item at a time. A transfer on in_ch starts the sequencer, which runs
// the multiplies and the inner-term add and subtracts through one shared ALU
// (a 32x32 multiply registered ahead of shift and saturate) and both gains
// through one radix-2 restoring divider. When s = c00 + noise_measure is
// not positive, both divides are skipped and the gains are zero. in_ch is
// not ready until the result has been transferred on out_ch, so a new item
// is not taken before the last result has left.
// A stalled receiver holds the result in the output register and blocks the
// next input. Reset clears angle, bias and covariance to zero and loads the
// register defaults; configuration is to be written only while idle, which the block itself does not enforce.
`default_nettype none
module angle_bias_kalman_filter_unit
    import abkf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    abkf_if.sink                    in_ch,
    abkf_if.source                  out_ch,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_idx,
    input  wire logic [REG_W-1:0]   cfg_data
);
    abkf_state_t state_reg, state_next;
    logic [REG_W-1:0] dt_reg, rs_reg, na_reg, nb_reg, nm_reg;
    logic signed [DATA_W-1:0] ang_reg, bias_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [DATA_W-1:0] t_reg, x_reg, k0_reg, k1_reg, y_reg, p00_reg, p01_reg;
    logic signed [DATA_W-1:0] s_reg;
    logic signed [MEAS_W-1:0] meas_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic                     mph_reg;   // multiply result phase: ALU product registered
    logic [2*DATA_W-1:0]      out_reg;
    logic                     ov_reg;

    abkf_op_t                 op;
    logic signed [DATA_W-1:0] a, b, res;
    logic                     div_start;
    logic signed [DATA_W-1:0] div_num;
    abkf_div_ctrl_t           dctl;
    logic signed [DATA_W-1:0] quo;
    logic signed [2*DATA_W-1:0] crw;
    logic signed [DATA_W-1:0] cr_sat;
    logic                     mul_st;

    abkf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .clk(clk), .op(op), .a(a), .b(b), .res(res));

    abkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(s_reg),
        .ctrl(dctl), .quo(quo));

    function automatic logic signed [DATA_W-1:0] ext(input logic [REG_W-1:0] v);
        return DATA_W'(v);
    endfunction

    assign in_ch.ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = out_reg;

    // cr saturates when the bits above the sign bit disagree
    always_comb
    begin
        crw = ((2*DATA_W)'(rate_reg) <<< FRAC_BITS) - (2*DATA_W)'(bias_reg);
        if (&crw[2*DATA_W-1:DATA_W-1] || ~|crw[2*DATA_W-1:DATA_W-1])
            cr_sat = crw[DATA_W-1:0];
        else if (crw[2*DATA_W-1])
            cr_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            cr_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // operand selection
    always_comb
    begin
        op = OP_MUL; a = '0; b = '0; mul_st = 1'b1;
        div_start = 1'b0; div_num = c00_reg;
        case (state_reg)
            ST_ANG:     begin a = x_reg; b = ext(rs_reg); end
            ST_T:       begin a = ext(dt_reg); b = c11_reg; end
            ST_INNER:   begin a = t_reg; b = c01_reg; op = OP_SUB; mul_st = 1'b0; end
            ST_INNER_B: begin a = x_reg; b = c10_reg; op = OP_SUB; mul_st = 1'b0; end
            ST_INNER_C: begin a = x_reg; b = ext(na_reg); op = OP_ADD; mul_st = 1'b0; end
            ST_C00:     begin a = ext(dt_reg); b = x_reg; end
            ST_C11:     begin a = ext(nb_reg); b = ext(dt_reg); end
            ST_CA:      begin a = k0_reg; b = y_reg; end
            ST_CB:      begin a = k1_reg; b = y_reg; end
            ST_P00:     begin a = k0_reg; b = p00_reg; end
            ST_P01:     begin a = k0_reg; b = p01_reg; end
            ST_P10:     begin a = k1_reg; b = p00_reg; end
            ST_P11:     begin a = k1_reg; b = p01_reg; end
            ST_K0:      begin div_start = (s_reg > 0); mul_st = 1'b0; end
            ST_K1:      begin div_start = 1'b1; div_num = c10_reg; mul_st = 1'b0; end
            default:    mul_st = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_ch.valid && in_ch.ready) state_next = ST_CR;
            ST_CR:      state_next = ST_ANG;
            ST_ANG:     if (mph_reg) state_next = ST_T;
            ST_T:       if (mph_reg) state_next = ST_INNER;
            ST_INNER:   state_next = ST_INNER_B;
            ST_INNER_B: state_next = ST_INNER_C;
            ST_INNER_C: state_next = ST_C00;
            ST_C00:     if (mph_reg) state_next = ST_C0110;
            ST_C0110:   state_next = ST_C11;
            ST_C11:     if (mph_reg) state_next = ST_S;
            ST_S:       state_next = ST_K0;
            ST_K0:      state_next = (s_reg > 0) ? ST_K0W : ST_Y;
            ST_K0W:     if (dctl.done) state_next = ST_K1;
            ST_K1:      state_next = ST_K1W;
            ST_K1W:     if (dctl.done) state_next = ST_Y;
            ST_Y:       state_next = ST_CA;
            ST_CA:      if (mph_reg) state_next = ST_CB;
            ST_CB:      if (mph_reg) state_next = ST_P00;
            ST_P00:     if (mph_reg) state_next = ST_P01;
            ST_P01:     if (mph_reg) state_next = ST_P10;
            ST_P10:     if (mph_reg) state_next = ST_P11;
            ST_P11:     if (mph_reg) state_next = ST_OUT;
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mph_reg <= 1'b0;
            ov_reg <= 1'b0;
            dt_reg <= RST_DELTA_T; rs_reg <= RST_RATE_SCALE; na_reg <= RST_NOISE_ANGLE;
            nb_reg <= RST_NOISE_BIAS; nm_reg <= RST_NOISE_MEASURE;
            ang_reg <= '0; bias_reg <= '0;
            c00_reg <= '0; c01_reg <= '0; c10_reg <= '0; c11_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mph_reg <= mul_st && !mph_reg;
            if (out_ch.valid && out_ch.ready) ov_reg <= 1'b0;
            if (state_reg == ST_OUT) ov_reg <= 1'b1;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_DELTA_T:       dt_reg <= cfg_data;
                    REG_RATE_SCALE:    rs_reg <= cfg_data;
                    REG_NOISE_ANGLE:   na_reg <= cfg_data;
                    REG_NOISE_BIAS:    nb_reg <= cfg_data;
                    REG_NOISE_MEASURE: nm_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (mph_reg)
            begin
                case (state_reg)
                    ST_ANG:  ang_reg  <= sat32({{2{ang_reg[DATA_W-1]}}, ang_reg}
                                               + {{2{res[DATA_W-1]}}, res});
                    ST_T:    t_reg    <= res;
                    ST_C00:  c00_reg  <= sat32({{2{c00_reg[DATA_W-1]}}, c00_reg}
                                               + {{2{res[DATA_W-1]}}, res});
                    ST_C11:  c11_reg  <= sat32({{2{c11_reg[DATA_W-1]}}, c11_reg}
                                               + {{2{res[DATA_W-1]}}, res});
                    ST_CA:   ang_reg  <= sat32({{2{ang_reg[DATA_W-1]}}, ang_reg}
                                               + {{2{res[DATA_W-1]}}, res});
                    ST_CB:   bias_reg <= sat32({{2{bias_reg[DATA_W-1]}}, bias_reg}
                                               + {{2{res[DATA_W-1]}}, res});
                    ST_P00:  c00_reg  <= sat32({{2{c00_reg[DATA_W-1]}}, c00_reg}
                                               - {{2{res[DATA_W-1]}}, res});
                    ST_P01:  c01_reg  <= sat32({{2{c01_reg[DATA_W-1]}}, c01_reg}
                                               - {{2{res[DATA_W-1]}}, res});
                    ST_P10:  c10_reg  <= sat32({{2{c10_reg[DATA_W-1]}}, c10_reg}
                                               - {{2{res[DATA_W-1]}}, res});
                    ST_P11:  c11_reg  <= sat32({{2{c11_reg[DATA_W-1]}}, c11_reg}
                                               - {{2{res[DATA_W-1]}}, res});
                    default: ;
                endcase
            end
            case (state_reg)
                ST_C0110:
                begin
                    c01_reg <= sat32({{2{c01_reg[DATA_W-1]}}, c01_reg}
                                     - {{2{t_reg[DATA_W-1]}}, t_reg});
                    c10_reg <= sat32({{2{c10_reg[DATA_W-1]}}, c10_reg}
                                     - {{2{t_reg[DATA_W-1]}}, t_reg});
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            meas_reg <= in_ch.data[MEAS_W-1:0];
            rate_reg <= in_ch.data[MEAS_W+RATE_W-1:MEAS_W];
        end
        case (state_reg)
            ST_CR:    x_reg <= cr_sat;
            ST_INNER, ST_INNER_B, ST_INNER_C:
                      x_reg <= res;
            ST_S:     s_reg <= sat32({{2{c00_reg[DATA_W-1]}}, c00_reg}
                                     + (DATA_W+2)'(nm_reg));
            ST_K0:
            begin
                k0_reg <= '0;
                k1_reg <= '0;
            end
            ST_K0W:   if (dctl.done) k0_reg <= quo;
            ST_K1W:   if (dctl.done) k1_reg <= quo;
            ST_Y:
            begin
                y_reg <= sat32({{(DATA_W-MEAS_W+2){meas_reg[MEAS_W-1]}}, meas_reg}
                               - {{2{ang_reg[DATA_W-1]}}, ang_reg});
                p00_reg <= c00_reg;
                p01_reg <= c01_reg;
            end
            ST_OUT:   out_reg <= {bias_reg, ang_reg};
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> (ov_reg && $stable(out_reg))) else $error("result lost");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dctl.busy |-> (state_reg == ST_K0W || state_reg == ST_K1W)) else $error("div stray");
`endif
endmodule
`default_nettype wire

>>> test/angle_bias_kalman_filter_unit_tb.sv
module angle_bias_kalman_filter_unit_tb
    import abkf_pkg::*;
();

    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic signed [MEAS_W-1:0] meas;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] bias;
        logic signed [DATA_W-1:0] angle;
    } estimate_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [REG_W-1:0] cfg_data;

    abkf_if #(.W(RATE_W + MEAS_W)) in_ch ();
    abkf_if #(.W(2 * DATA_W)) out_ch ();

    angle_bias_kalman_filter_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    // filter state mirrored in the bench
    logic [REG_W-1:0] dt_r, rs_r, na_r, nb_r, nm_r;
    logic signed [31:0] ang_s, bias_s, c00, c01, c10, c11;

    sample_t sample_q[$];
    estimate_t estimate_q[$];

    int errors;
    int mismatches;
    int checked;
    int idle_cycles;
    int stall_hold;
    int send_gap;
    int recv_gap;
    bit timed_out;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat(p >>> 16);   // arithmetic shift == floor
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [31:0] n,
                                                input logic signed [31:0] d);
        logic signed [63:0] num;
        num = 64'(n) <<< 16;
        return sat(num / 64'(d));
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat(64'(a) - 64'(b));
    endfunction

    function automatic estimate_t kalman_update(input sample_t s);
        logic signed [31:0] dt, cr, t, inner, sv, k0, k1, y, p00, p01;
        estimate_t e;
        dt = $signed({15'd0, dt_r});
        cr = sat((64'(s.rate) <<< 16) - 64'(bias_s));
        ang_s = qadd(ang_s, qmul(cr, $signed({15'd0, rs_r})));
        t = qmul(dt, c11);
        inner = qadd(qsub(qsub(t, c01), c10), $signed({15'd0, na_r}));
        c00 = qadd(c00, qmul(dt, inner));
        c01 = qsub(c01, t);
        c10 = qsub(c10, t);
        c11 = qadd(c11, qmul($signed({15'd0, nb_r}), dt));
        sv = qadd(c00, $signed({15'd0, nm_r}));
        if (sv > 0)
        begin
            k0 = qdiv(c00, sv);
            k1 = qdiv(c10, sv);
        end
        else
        begin
            k0 = 0;
            k1 = 0;
        end
        y = qsub(32'(s.meas), ang_s);
        ang_s = qadd(ang_s, qmul(k0, y));
        bias_s = qadd(bias_s, qmul(k1, y));
        p00 = c00;
        p01 = c01;
        c00 = qsub(c00, qmul(k0, p00));
        c01 = qsub(c01, qmul(k0, p01));
        c10 = qsub(c10, qmul(k1, p00));
        c11 = qsub(c11, qmul(k1, p01));
        e.angle = ang_s;
        e.bias = bias_s;
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            send_gap <= 0;
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
            // hold the offered item
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                estimate_q.push_back(kalman_update(sample_t'(in_ch.data)));
            if (send_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (sample_q.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= sample_q.pop_front();
                send_gap <= pick_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                estimate_t got, want;
                got = estimate_t'(out_ch.data);
                checked++;
                if (estimate_q.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result angle=%0d bias=%0d", got.angle, got.bias);
                end
                else
                begin
                    want = estimate_q.pop_front();
                    if (got.angle !== want.angle || got.bias !== want.bias)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("result %0d: angle exp %0d got %0d, bias exp %0d got %0d",
                                     checked, want.angle, got.angle, want.bias, got.bias);
                    end
                end
            end
            if (stall_hold > 0)
                out_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready)
                    recv_gap <= pick_gap();
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
        if (stall_hold > 0)
            stall_hold <= stall_hold - 1;

    // watchdog
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELTA_T:       dt_r = val;
            REG_RATE_SCALE:    rs_r = val;
            REG_NOISE_ANGLE:   na_r = val;
            REG_NOISE_BIAS:    nb_r = val;
            REG_NOISE_MEASURE: nm_r = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || estimate_q.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic sample_t rand_sample(input bit wild);
        sample_t s;
        int r;
        r = $urandom_range(0, 9);
        if (wild || r == 0)
            s.meas = MEAS_W'($urandom);
        else
            s.meas = MEAS_W'($signed($urandom_range(0, 2 * 23592960)) - 23592960);
        s.rate = RATE_W'($urandom);
        return s;
    endfunction

    function automatic logic [REG_W-1:0] rand_reg(input bit nonzero);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return nonzero ? 17'd1 : 17'd0;
        if (r == 1)
            return 17'd65536;
        if (r == 2)
            return REG_W'($urandom);   // any 17-bit value
        return REG_W'($urandom_range(nonzero ? 1 : 0, 4000));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        errors = 0;
        mismatches = 0;
        checked = 0;
        idle_cycles = 0;
        stall_hold = 0;
        timed_out = 1'b0;
        dt_r = RST_DELTA_T;
        rs_r = RST_RATE_SCALE;
        na_r = RST_NOISE_ANGLE;
        nb_r = RST_NOISE_BIAS;
        nm_r = RST_NOISE_MEASURE;
        ang_s = 0; bias_s = 0; c00 = 0; c01 = 0; c10 = 0; c11 = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: defaults, field extremes
        sample_q.push_back('{meas: 26'sd0, rate: 16'sd0});
        sample_q.push_back('{meas: 26'sd23592960, rate: 16'sh7fff});
        sample_q.push_back('{meas: -26'sd23592960, rate: 16'sh8000});
        sample_q.push_back('{meas: 26'sh1ffffff, rate: 16'sh7fff});
        sample_q.push_back('{meas: 26'sh2000000, rate: 16'sh8000});
        sample_q.push_back('{meas: 26'sh3ffffff, rate: -16'sd1});
        drain();

        // zero measurement, angle and bias noise
        write_reg(REG_NOISE_MEASURE, 17'd0);
        write_reg(REG_NOISE_ANGLE, 17'd0);
        write_reg(REG_NOISE_BIAS, 17'd0);
        sample_q.push_back('{meas: 26'sd1000000, rate: 16'sd100});
        sample_q.push_back('{meas: -26'sd1000000, rate: -16'sd100});
        drain();

        // maxima, an unknown index and an over-range value
        write_reg(REG_DELTA_T, 17'd65536);
        write_reg(REG_RATE_SCALE, 17'd65536);
        write_reg(REG_NOISE_ANGLE, 17'd65536);
        write_reg(REG_NOISE_BIAS, 17'h1ffff);
        write_reg(REG_NOISE_MEASURE, 17'd65536);
        write_reg(3'd6, 17'd12345);
        for (int i = 0; i < 8; i++)
            sample_q.push_back(rand_sample(i[0]));
        drain();

        // minima
        write_reg(REG_DELTA_T, 17'd1);
        write_reg(REG_RATE_SCALE, 17'd0);
        write_reg(REG_NOISE_MEASURE, 17'd1);
        for (int i = 0; i < 6; i++)
            sample_q.push_back(rand_sample(1'b0));
        drain();

        // random phases with new settings; one phase runs into a long stall
        for (int ph = 0; ph < 16; ph++)
        begin
            write_reg(REG_DELTA_T, rand_reg(1'b1));
            write_reg(REG_RATE_SCALE, rand_reg(1'b0));
            write_reg(REG_NOISE_ANGLE, rand_reg(1'b0));
            write_reg(REG_NOISE_BIAS, rand_reg(1'b0));
            write_reg(REG_NOISE_MEASURE, rand_reg(ph % 5 != 3));
            if (ph == 4)
                stall_hold <= 3000;
            for (int i = 0; i < 100; i++)
                sample_q.push_back(rand_sample($urandom_range(0, 19) == 0));
            drain();
        end

        $display("covered %0d filter updates over 20 register settings,", checked);
        $display("including extremes, zero gain and a long output stall");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
